### rtl/assert_macros.svh
// Assertion macros shared by the clock RTL modules.
// Depends on nothing; included by the files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/thc_pkg.sv
// Shared types, constants and the digit decode for the twelve-hour clock.
// No dependencies; imported by every module of the block.
package thc_pkg;

    localparam logic [1:0] OP_TICK       = 2'd0;
    localparam logic [1:0] OP_MINUTE_SET = 2'd1;
    localparam logic [1:0] OP_HOUR_SET   = 2'd2;

    localparam logic [5:0] SECOND_TOP      = 6'd59;
    localparam logic [5:0] MINUTE_TOP      = 6'd59;
    localparam logic [3:0] HOUR_TOP        = 4'd11;
    localparam logic [9:0] THRESHOLD_RESET = 10'd750;

    typedef struct packed {
        logic [1:0] opcode;
        logic [9:0] sample;
    } thc_req_t;

    typedef struct packed {
        logic [3:0] hours;
        logic [5:0] minutes_now;
        logic [5:0] seconds_now;
        logic       press_seen;
        logic [6:0] seg_hour_tens;
        logic [6:0] seg_hour_ones;
        logic [6:0] seg_minute_tens;
        logic [6:0] seg_minute_ones;
    } thc_res_t;

    typedef struct packed {
        logic [3:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
    } thc_time_t;

    typedef struct packed {
        logic [6:0] hour_tens;
        logic [6:0] hour_ones;
        logic [6:0] minute_tens;
        logic [6:0] minute_ones;
    } thc_seg_t;

    // Segment pattern of one decimal digit, bit 0 segment a up to bit 6 segment g.
    function automatic logic [6:0] seg_of_digit(input logic [3:0] digit);
        logic [6:0] pattern;
        unique case (digit)
            4'd0:    pattern = 7'h3F;
            4'd1:    pattern = 7'h06;
            4'd2:    pattern = 7'h5B;
            4'd3:    pattern = 7'h4F;
            4'd4:    pattern = 7'h66;
            4'd5:    pattern = 7'h6D;
            4'd6:    pattern = 7'h7D;
            4'd7:    pattern = 7'h07;
            4'd8:    pattern = 7'h7F;
            4'd9:    pattern = 7'h67;
            default: pattern = 7'h00;
        endcase
        return pattern;
    endfunction

endpackage

### rtl/thc_time_core.sv
// Time-of-day counters and their per-request update.
// Depends on thc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module thc_time_core
    import thc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  thc_req_t   req,
    input  logic [9:0] threshold,
    output thc_time_t  time_next,
    output logic       press
);

    thc_time_t time_reg;

    logic       sec_wrap;
    logic       min_wrap;
    logic [5:0] sec_inc;
    logic [5:0] min_inc;
    logic [3:0] hour_inc;

    assign sec_wrap = time_reg.seconds >= SECOND_TOP;
    assign min_wrap = time_reg.minutes >= MINUTE_TOP;
    assign sec_inc  = sec_wrap ? 6'd0 : time_reg.seconds + 6'd1;
    assign min_inc  = min_wrap ? 6'd0 : time_reg.minutes + 6'd1;
    assign hour_inc = (time_reg.hours >= HOUR_TOP) ? 4'd0 : time_reg.hours + 4'd1;

    assign press = ((req.opcode == OP_MINUTE_SET) || (req.opcode == OP_HOUR_SET))
                   && (req.sample > threshold);

    always_comb
    begin
        time_next = time_reg;
        unique case (req.opcode)
            OP_TICK:
            begin
                time_next.seconds = sec_inc;
                if (sec_wrap)
                begin
                    time_next.minutes = min_inc;
                    if (min_wrap)
                    begin
                        time_next.hours = hour_inc;
                    end
                end
            end
            OP_MINUTE_SET:
            begin
                if (press)
                begin
                    time_next.minutes = min_inc;
                    if (min_wrap)
                    begin
                        time_next.hours = hour_inc;
                    end
                end
            end
            OP_HOUR_SET:
            begin
                if (press)
                begin
                    time_next.hours = hour_inc;
                end
            end
            default:
            begin
                time_next = time_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg <= '0;
        end
        else if (step)
        begin
            time_reg <= time_next;
        end
    end

    `ASSERT_ALWAYS(a_hours_range, clk, rst_n, time_reg.hours <= HOUR_TOP, "hours out of range")
    `ASSERT_ALWAYS(a_minsec_range, clk, rst_n,
        (time_reg.minutes <= MINUTE_TOP) && (time_reg.seconds <= SECOND_TOP),
        "minutes or seconds out of range")
    `ASSERT_NEXT(a_hold_when_idle, clk, rst_n, !step, $stable(time_reg),
        "time changed without a request")

endmodule

### rtl/thc_seg_decode.sv
// Splits hours and minutes into decimal digits and maps them to segment patterns.
// Depends on thc_pkg.
module thc_seg_decode
    import thc_pkg::*;
(
    input  thc_time_t tm,
    output thc_seg_t  seg
);

    logic [3:0] hour_tens;
    logic [3:0] hour_ones;
    logic [3:0] min_tens;
    logic [5:0] min_base;
    logic [3:0] min_ones;
    logic [5:0] min_rem;

    // Hours stay below 20, so one compare splits the digits.
    always_comb
    begin
        if (tm.hours >= 4'd10)
        begin
            hour_tens = 4'd1;
            hour_ones = tm.hours - 4'd10;
        end
        else
        begin
            hour_tens = 4'd0;
            hour_ones = tm.hours;
        end
    end

    // Minutes stay below 60: pick the tens digit by compare.
    always_comb
    begin
        priority if (tm.minutes >= 6'd50)
        begin
            min_tens = 4'd5;
            min_base = 6'd50;
        end
        else if (tm.minutes >= 6'd40)
        begin
            min_tens = 4'd4;
            min_base = 6'd40;
        end
        else if (tm.minutes >= 6'd30)
        begin
            min_tens = 4'd3;
            min_base = 6'd30;
        end
        else if (tm.minutes >= 6'd20)
        begin
            min_tens = 4'd2;
            min_base = 6'd20;
        end
        else if (tm.minutes >= 6'd10)
        begin
            min_tens = 4'd1;
            min_base = 6'd10;
        end
        else
        begin
            min_tens = 4'd0;
            min_base = 6'd0;
        end
    end

    assign min_rem  = tm.minutes - min_base;
    assign min_ones = min_rem[3:0];

    assign seg.hour_tens   = seg_of_digit(hour_tens);
    assign seg.hour_ones   = seg_of_digit(hour_ones);
    assign seg.minute_tens = seg_of_digit(min_tens);
    assign seg.minute_ones = seg_of_digit(min_ones);

endmodule

### rtl/twelve_hour_clock_seven_segment_unit.sv
// Twelve-hour clock with seven-segment decode: top level.
// A request waits in the request register until the result register is free or being taken; then
// its result moves there and drives out_valid. One request per cycle while out_stall is low;
// the counter update and decode sit between the request register and the result register.
// Reset: time clears to 00:00:00, threshold returns to 750, both stages empty.
// Depends on thc_pkg, thc_time_core, thc_seg_decode and assert_macros.svh.
`include "assert_macros.svh"

module twelve_hour_clock_seven_segment_unit
    import thc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  thc_req_t   in_req,
    output logic       out_valid,
    input  logic       out_stall,
    output thc_res_t   out_res,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [9:0] cfg_data
);

    logic       req_valid_reg;
    thc_req_t   req_reg;
    logic       out_valid_reg;
    thc_res_t   out_reg;
    logic [9:0] threshold_reg;

    logic       advance;
    logic       step;
    thc_time_t  time_next;
    logic       press;
    thc_seg_t   seg;
    thc_res_t   res_next;

    // Pipe moves when the result slot is free or being taken.
    assign advance  = !out_valid_reg || !out_stall;
    assign step     = req_valid_reg && advance;
    assign in_stall = req_valid_reg && !advance;

    assign cfg_ready = 1'b1;

    thc_time_core u_time_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .req       (req_reg),
        .threshold (threshold_reg),
        .time_next (time_next),
        .press     (press)
    );

    thc_seg_decode u_seg_decode (
        .tm  (time_next),
        .seg (seg)
    );

    always_comb
    begin
        res_next.hours           = time_next.hours;
        res_next.minutes_now     = time_next.minutes;
        res_next.seconds_now     = time_next.seconds;
        res_next.press_seen      = press;
        res_next.seg_hour_tens   = seg.hour_tens;
        res_next.seg_hour_ones   = seg.hour_ones;
        res_next.seg_minute_tens = seg.minute_tens;
        res_next.seg_minute_ones = seg.minute_ones;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            threshold_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= req_valid_reg;
            end
            if (!in_stall)
            begin
                req_valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            req_reg <= in_req;
        end
        if (step)
        begin
            out_reg <= res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

    `ASSERT_NEXT(a_step_fills_out, clk, rst_n, step, out_valid_reg,
        "processed request produced no result")
    `ASSERT_IMPLIES(a_tick_no_press, clk, rst_n,
        step && (req_reg.opcode == OP_TICK), !press,
        "press flagged on a tick")
    `ASSERT_IMPLIES(a_stall_when_blocked, clk, rst_n,
        in_stall, out_valid_reg && out_stall,
        "request stalled while the result slot can move")

endmodule
